### sv/trps_pkg.sv
// Shared types and constants for the thread ready table.
// No dependencies; every other file depends on this package.
`default_nettype none

package trps_pkg;

    localparam int TableDepth = 16;
    localparam int IdBits     = 8;
    localparam int PrioBits   = 10;
    localparam int CountBits  = $clog2(TableDepth + 1);
    localparam int OpBits     = 3;
    localparam int StatusBits = 2;

    localparam logic [PrioBits-1:0] PrioCeiling = PrioBits'(999);

    typedef enum logic [OpBits-1:0] {
        OP_INIT    = 3'd0,
        OP_ENQUEUE = 3'd1,
        OP_REMOVE  = 3'd2,
        OP_TEST    = 3'd3,
        OP_SELECT  = 3'd4
    } op_e;

    typedef enum logic [StatusBits-1:0] {
        ST_OK        = 2'd0,
        ST_INIT_BUSY = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_e;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_e;

    // One table slot as seen by its neighbors.
    typedef struct packed {
        logic                valid;
        logic [IdBits-1:0]   id;
        logic [PrioBits-1:0] prio;
    } entry_t;

    // Scan token, carried one cell per cycle.
    typedef struct packed {
        logic                active;
        logic                hit;
        logic                sel_valid;
        logic [IdBits-1:0]   best_id;
        logic [PrioBits-1:0] best_prio;
    } tok_t;

    // Commands broadcast to every cell.
    typedef struct packed {
        logic insert;
        logic compact;
    } cell_cmd_t;

endpackage

`default_nettype wire

### sv/trps_ifs.sv
// Handshake channel interfaces: request, response and config write.
// Depends on trps_pkg for field widths.
`default_nettype none

interface trps_req_if;
    logic                            valid;
    logic                            ready;
    logic [trps_pkg::OpBits-1:0]     op;
    logic [trps_pkg::IdBits-1:0]     thread_id;
    logic                            has_priority;
    logic [trps_pkg::PrioBits-1:0]   priority_req;

    modport source (output valid, op, thread_id, has_priority, priority_req, input ready);
    modport sink   (input valid, op, thread_id, has_priority, priority_req, output ready);
endinterface

interface trps_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [trps_pkg::StatusBits-1:0]  status;
    logic                             found;
    logic                             select_valid;
    logic [trps_pkg::IdBits-1:0]      select_id;
    logic [trps_pkg::PrioBits-1:0]    select_priority;
    logic [trps_pkg::CountBits-1:0]   occupancy;

    modport source (output valid, status, found, select_valid, select_id,
                    select_priority, occupancy, input ready);
    modport sink   (input valid, status, found, select_valid, select_id,
                    select_priority, occupancy, output ready);
endinterface

interface trps_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [trps_pkg::PrioBits-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### sv/thread_ready_table_priority_select.sv
// Thread ready table with lowest-priority select: top level.
// Needs trps_pkg, trps_ifs, trps_cell, trps_ctrl.
//
// Usage:
//   req carries one operation (init, enqueue, remove, test, select) per item;
//   rsp returns exactly one result item per request; cfg writes the default
//   priority used for threads inserted without their own priority.
//   Entries live in a row of TableDepth cells, front at cell 0. Insert shifts
//   every cell at once, and remove compaction every cell from the first
//   match back. Remove, test and select send a token down the chain, one cell
//   a cycle, which gathers the match and the lowest priority seen below 999.
// Path to rsp.valid: init/enqueue go from accept to the finish state, which
//   fills the output register; remove/test/select first pass the token through
//   start_reg and every cell register. One item is in work at a time.
// A result waits in the output register while the next item is taken; the
//   block stalls only when a new result is ready and rsp is still held.
// Reset empties the table (occupancy 0) and sets the default priority to 0.
`default_nettype none

module thread_ready_table_priority_select (
    input  wire logic  clk,
    input  wire logic  rst_n,
    trps_req_if.sink   req,
    trps_rsp_if.source rsp,
    trps_cfg_if.sink   cfg
);
    import trps_pkg::*;

    cell_cmd_t         cmd;
    logic [IdBits-1:0] key;
    entry_t            new_entry;
    entry_t            ent [TableDepth];
    tok_t              tok [TableDepth+1];

    trps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg       (cfg),
        .cmd       (cmd),
        .key       (key),
        .new_entry (new_entry),
        .tok_first (tok[0]),
        .tok_last  (tok[TableDepth])
    );

    for (genvar k = 0; k < TableDepth; k++)
    begin : g_cell
        entry_t left_ent;
        entry_t right_ent;

        if (k == 0)
        begin : g_front
            assign left_ent = new_entry;
        end
        else
        begin : g_mid_left
            assign left_ent = ent[k-1];
        end

        if (k == TableDepth - 1)
        begin : g_back
            assign right_ent = '0;
        end
        else
        begin : g_mid_right
            assign right_ent = ent[k+1];
        end

        trps_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .key     (key),
            .left    (left_ent),
            .right   (right_ent),
            .tok_in  (tok[k]),
            .ent     (ent[k]),
            .tok_out (tok[k+1])
        );
    end

endmodule

`default_nettype wire

### sv/trps_cell.sv
// One table slot: holds an entry, shifts with its neighbors, and updates
// the scan token as it passes. Depends on trps_pkg.
`default_nettype none

module trps_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire trps_pkg::cell_cmd_t         cmd,
    input  wire logic [trps_pkg::IdBits-1:0] key,
    input  wire trps_pkg::entry_t            left,
    input  wire trps_pkg::entry_t            right,
    input  wire trps_pkg::tok_t              tok_in,
    output trps_pkg::entry_t                 ent,
    output trps_pkg::tok_t                   tok_out
);
    import trps_pkg::*;

    logic                valid_reg, valid_next;
    logic [IdBits-1:0]   id_reg, id_next;
    logic [PrioBits-1:0] prio_reg, prio_next;
    logic                mark_reg, mark_next;
    tok_t                tok_reg, tok_next;
    logic                match;
    logic                better;

    always_comb
    begin
        match  = valid_reg && (id_reg == key);
        better = valid_reg && (prio_reg < tok_in.best_prio);

        tok_next     = tok_in;
        tok_next.hit = tok_in.hit | match;
        if (better)
        begin
            tok_next.sel_valid = 1'b1;
            tok_next.best_id   = id_reg;
            tok_next.best_prio = prio_reg;
        end

        // mark: this slot is at or behind the first match
        mark_next = tok_in.active ? tok_next.hit : mark_reg;

        valid_next = valid_reg;
        id_next    = id_reg;
        prio_next  = prio_reg;
        if (cmd.insert)
        begin
            valid_next = left.valid;
            id_next    = left.id;
            prio_next  = left.prio;
        end
        else if (cmd.compact && mark_reg)
        begin
            valid_next = right.valid;
            id_next    = right.id;
            prio_next  = right.prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            mark_reg  <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            mark_reg  <= mark_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

    assign ent     = '{valid: valid_reg, id: id_reg, prio: prio_reg};
    assign tok_out = tok_reg;

endmodule

`default_nettype wire

### sv/trps_ctrl.sv
// Sequencer: takes requests and config writes, launches scans along the
// cell chain, commits table changes and holds the response. Needs trps_pkg, trps_ifs.
`default_nettype none

module trps_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    trps_req_if.sink                         req,
    trps_rsp_if.source                       rsp,
    trps_cfg_if.sink                         cfg,
    output trps_pkg::cell_cmd_t              cmd,
    output logic [trps_pkg::IdBits-1:0]      key,
    output trps_pkg::entry_t                 new_entry,
    output trps_pkg::tok_t                   tok_first,
    input  wire trps_pkg::tok_t              tok_last
);
    import trps_pkg::*;

    state_e               state_reg, state_next;
    op_e                  op_reg, op_next;
    logic [IdBits-1:0]    key_reg, key_next;
    logic [PrioBits-1:0]  prio_reg, prio_next;
    logic [PrioBits-1:0]  dflt_reg, dflt_next;
    logic [CountBits-1:0] count_reg, count_next;
    logic                 start_reg, start_next;
    tok_t                 res_reg, res_next;

    logic                 out_valid_reg, out_valid_next;
    status_e              out_status_reg, out_status_next;
    logic                 out_found_reg, out_found_next;
    logic                 out_sel_valid_reg, out_sel_valid_next;
    logic [IdBits-1:0]    out_sel_id_reg, out_sel_id_next;
    logic [PrioBits-1:0]  out_sel_prio_reg, out_sel_prio_next;
    logic [CountBits-1:0] out_count_reg, out_count_next;

    logic                 accept;
    logic                 can_write;
    logic                 is_scan_op;
    logic                 full;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;
    assign can_write = !out_valid_reg || rsp.ready;
    assign full      = (count_reg == CountBits'(TableDepth));

    always_comb
    begin
        case (op_e'(req.op))
            OP_REMOVE, OP_TEST, OP_SELECT: is_scan_op = 1'b1;
            default:                       is_scan_op = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        prio_next   = prio_reg;
        count_next  = count_reg;
        start_next  = 1'b0;
        res_next    = res_reg;
        dflt_next   = (cfg.valid && cfg.ready) ? cfg.data : dflt_reg;
        cmd         = '0;

        out_valid_next     = out_valid_reg && !rsp.ready;
        out_status_next    = out_status_reg;
        out_found_next     = out_found_reg;
        out_sel_valid_next = out_sel_valid_reg;
        out_sel_id_next    = out_sel_id_reg;
        out_sel_prio_next  = out_sel_prio_reg;
        out_count_next     = out_count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = op_e'(req.op);
                    key_next   = req.thread_id;
                    prio_next  = req.has_priority ? req.priority_req : dflt_reg;
                    start_next = is_scan_op;
                    state_next = is_scan_op ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN:
            begin
                if (tok_last.active)
                begin
                    res_next   = tok_last;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (can_write)
                begin
                    out_valid_next     = 1'b1;
                    out_status_next    = ST_OK;
                    out_found_next     = 1'b0;
                    out_sel_valid_next = 1'b0;
                    out_sel_id_next    = '0;
                    out_sel_prio_next  = '0;
                    case (op_reg)
                        OP_INIT, OP_ENQUEUE:
                        begin
                            if (op_reg == OP_INIT && count_reg != '0)
                                out_status_next = ST_INIT_BUSY;
                            else if (full)
                                out_status_next = ST_FULL;
                            else
                            begin
                                cmd.insert = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (res_reg.hit)
                            begin
                                cmd.compact = 1'b1;
                                count_next  = count_reg - 1'b1;
                            end
                            else
                                out_status_next = ST_NOT_FOUND;
                        end
                        OP_TEST:
                            out_found_next = res_reg.hit;
                        OP_SELECT:
                        begin
                            if (res_reg.sel_valid)
                            begin
                                out_sel_valid_next = 1'b1;
                                out_sel_id_next    = res_reg.best_id;
                                out_sel_prio_next  = res_reg.best_prio;
                            end
                        end
                        default: ;
                    endcase
                    out_count_next = count_next;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            start_reg     <= 1'b0;
            dflt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            start_reg     <= start_next;
            dflt_reg      <= dflt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg            <= op_next;
        key_reg           <= key_next;
        prio_reg          <= prio_next;
        res_reg           <= res_next;
        out_status_reg    <= out_status_next;
        out_found_reg     <= out_found_next;
        out_sel_valid_reg <= out_sel_valid_next;
        out_sel_id_reg    <= out_sel_id_next;
        out_sel_prio_reg  <= out_sel_prio_next;
        out_count_reg     <= out_count_next;
    end

    assign key       = key_reg;
    assign new_entry = '{valid: 1'b1, id: key_reg, prio: prio_reg};
    assign tok_first = '{active: start_reg, hit: 1'b0, sel_valid: 1'b0,
                         best_id: '0, best_prio: PrioCeiling};

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.found           = out_found_reg;
    assign rsp.select_valid    = out_sel_valid_reg;
    assign rsp.select_id       = out_sel_id_reg;
    assign rsp.select_priority = out_sel_prio_reg;
    assign rsp.occupancy       = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountBits'(TableDepth))
        else $error("occupancy above table depth");

    a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tok_last.active |-> state_reg == S_SCAN)
        else $error("scan token left the chain outside a scan");

    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("response raised outside finish");

    a_one_edit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.insert && cmd.compact))
        else $error("insert and compact in the same cycle");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted item did not start work");

endmodule

`default_nettype wire
